@@ hw/rtl/gorect_pkg.sv @@
// Shared package of the grid occupancy rectangle engine: grid geometry,
// field widths, operation and register codes, and controller/datapath structs.
// No dependencies.
package gorect_pkg;

    // Grid geometry
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 256;
    localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ADDR_W   = ROW_W + COL_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    // Field widths
    localparam int OPCODE_W = 1;
    localparam int RECT_X_W = 10;
    localparam int RECT_Y_W = 10;
    localparam int RECT_WIDTH_W  = 9;
    localparam int RECT_HEIGHT_W = 7;
    localparam int CODE_W   = 8;
    localparam int ROWS_CFG_W = 7;
    localparam int COLS_CFG_W = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // Signed coordinate width: holds x + width and the grid sizes
    localparam int CRD_W = 12;

    // Operation codes
    localparam logic [OPCODE_W-1:0] OP_FILL  = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_CHECK = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WALL_CODE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_CODE  = 2'd3;

    // Configuration reset values
    localparam logic [ROWS_CFG_W-1:0] ROWS_RST  = 7'd64;
    localparam logic [COLS_CFG_W-1:0] COLS_RST  = 9'd256;
    localparam logic [CODE_W-1:0]     WALL_RST  = 8'd35;
    localparam logic [CODE_W-1:0]     EMPTY_RST = 8'd0;

    // Controller to datapath
    typedef struct packed {
        logic clear;   // write zero at the sweep address and advance
        logic load;    // capture an accepted item
        logic issue;   // read the current cell and advance the scan
        logic finish;  // load the result register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;   // sweep is at its last entry
        logic skip;       // no cell to visit for this item
        logic scan_last;  // current cell is the last of the rectangle
        logic hit;        // check found an occupied cell
    } t_sts;

endpackage

@@ hw/rtl/gorect_in_if.sv @@
// Input channel of the grid occupancy rectangle engine: valid/ready plus one item.
// Depends on gorect_pkg.
interface gorect_in_if import gorect_pkg::*; ();
    logic                            valid;
    logic                            ready;
    logic        [OPCODE_W-1:0]      opcode;
    logic signed [RECT_X_W-1:0]      rect_x;
    logic signed [RECT_Y_W-1:0]      rect_y;
    logic        [RECT_WIDTH_W-1:0]  rect_width;
    logic        [RECT_HEIGHT_W-1:0] rect_height;
    logic        [CODE_W-1:0]        fill_value;

    modport source (
        output valid, opcode, rect_x, rect_y, rect_width, rect_height, fill_value,
        input  ready
    );
    modport sink (
        input  valid, opcode, rect_x, rect_y, rect_width, rect_height, fill_value,
        output ready
    );
endinterface

@@ hw/rtl/gorect_out_if.sv @@
// Result channel of the grid occupancy rectangle engine: valid/ready plus one result.
// Depends on gorect_pkg.
interface gorect_out_if import gorect_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] hit_code;
    logic              was_check;

    modport source (output valid, hit_code, was_check, input ready);
    modport sink   (input  valid, hit_code, was_check, output ready);
endinterface

@@ hw/rtl/grid_occupancy_rect_engine.sv @@
// Grid occupancy rectangle engine top level: joins controller and datapath
// to the item, result and configuration ports. Depends on gorect_pkg,
// gorect_in_if, gorect_out_if, gorect_ctrl and gorect_dp.

// After reset the engine sweeps the whole cell grid to zero, one cell per cycle
// (all 2**(ROW_W+COL_W) cells, 16384 for a 64 by 256 grid), and takes no item
// until the sweep ends; configuration writes are taken throughout. Items are
// handled one at a time: each goes from start through scan and drain to done,
// or from scan straight to done on a hit; a check that fails the border test, or a
// rectangle with nothing inside the grid, goes from start straight to done. A
// check stops its scan once it has read the first occupied cell. The single read
// port of the grid memory visits one cell per cycle. The input is taken again
// while a result still waits in the output register.
module grid_occupancy_rect_engine import gorect_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gorect_in_if.sink             i_item,
    gorect_out_if.source          o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    gorect_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    gorect_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_opcode      (i_item.opcode),
        .i_rect_x      (i_item.rect_x),
        .i_rect_y      (i_item.rect_y),
        .i_rect_width  (i_item.rect_width),
        .i_rect_height (i_item.rect_height),
        .i_fill_value  (i_item.fill_value),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_hit_code    (o_result.hit_code),
        .o_was_check   (o_result.was_check)
    );

    // no item is taken during the clearing sweep
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear |-> !i_item.ready)
        else $error("item ready during clearing sweep");

    // one item at a time
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> !i_item.ready)
        else $error("input ready right after an item transfer");

    // a result is only loaded into a free or draining output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.finish && o_result.valid) |-> o_result.ready)
        else $error("result register overwritten before transfer");

    a_finish_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> o_result.valid)
        else $error("finished result not presented");

    // the scan never runs together with the sweep or an item load
    a_scan_not_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.issue |-> (!cmd.clear && !cmd.load))
        else $error("scan read overlaps sweep or item load");

endmodule

@@ hw/rtl/gorect_ctrl.sv @@
// Controller of the grid occupancy rectangle engine: clearing sweep, item
// sequencing and the result valid flag. Depends on gorect_pkg.
module gorect_ctrl import gorect_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_START = 6'b000100,
        S_SCAN  = 6'b001000,
        S_DRAIN = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_vld;

    always_comb begin
        o_cmd        = '0;
        o_cmd.clear  = (r_state == S_CLEAR);
        o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.issue  = (r_state == S_SCAN) && !i_sts.hit;
        o_cmd.finish = (r_state == S_DONE) && (!r_out_vld || i_out_ready);
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_START;
            end
            S_START: begin
                n_state = i_sts.skip ? S_DONE : S_SCAN;
            end
            S_SCAN: begin
                // stop early on a hit; the reads still in flight are ignored
                if (i_sts.hit) n_state = S_DONE;
                else if (i_sts.scan_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || i_out_ready) n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.finish) r_out_vld <= 1'b1;
            else if (i_out_ready) r_out_vld <= 1'b0;
        end
    end

endmodule

@@ hw/rtl/gorect_dp.sv @@
// Datapath of the grid occupancy rectangle engine: configuration registers,
// rectangle bounds, scan counters, the cell grid memory and the result register.
// Depends on gorect_pkg.
module gorect_dp import gorect_pkg::*; (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic        [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic        [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic        [OPCODE_W-1:0]      i_opcode,
    input  logic signed [RECT_X_W-1:0]      i_rect_x,
    input  logic signed [RECT_Y_W-1:0]      i_rect_y,
    input  logic        [RECT_WIDTH_W-1:0]  i_rect_width,
    input  logic        [RECT_HEIGHT_W-1:0] i_rect_height,
    input  logic        [CODE_W-1:0]        i_fill_value,
    input  t_cmd                            i_cmd,
    output t_sts                            o_sts,
    output logic        [CODE_W-1:0]        o_hit_code,
    output logic                            o_was_check
);

    // Configuration
    logic [ROWS_CFG_W-1:0] r_rows_in_use;
    logic [COLS_CFG_W-1:0] r_cols_in_use;
    logic [CODE_W-1:0]     r_wall_code;
    logic [CODE_W-1:0]     r_empty_code;

    // Item and scan state
    logic [OPCODE_W-1:0] r_op;
    logic [CODE_W-1:0]   r_code;
    logic                r_skip;
    logic                r_wall_hit;
    logic [ROW_W-1:0]    r_row;
    logic [ROW_W:0]      r_row_end;
    logic [COL_W-1:0]    r_col;
    logic [COL_W-1:0]    r_col_start;
    logic [COL_W:0]      r_col_end;
    logic                r_hit;
    logic [CODE_W-1:0]   r_hit_val;

    // Read stage
    logic                r_rd_vld;
    logic [ADDR_W-1:0]   r_rd_addr;
    logic [CODE_W-1:0]   r_q;

    // Clearing sweep
    logic [ADDR_W-1:0]   r_clr_addr;

    // Result
    logic [CODE_W-1:0]   r_res_code;
    logic                r_res_check;

    logic [CODE_W-1:0]   r_mem [MEM_DEPTH];

    // Bounds of the incoming item
    logic signed [CRD_W-1:0] x_s, y_s, w_s, h_s, rows_e, cols_e;
    logic signed [CRD_W-1:0] x_end, y_end, r0, r1, c0, c1;
    logic                    border, empty_rng;

    always_comb begin
        x_s    = CRD_W'(i_rect_x);
        y_s    = CRD_W'(i_rect_y);
        w_s    = signed'(CRD_W'(i_rect_width));
        h_s    = signed'(CRD_W'(i_rect_height));
        rows_e = (r_rows_in_use > MAX_ROWS) ? CRD_W'(MAX_ROWS)
                                            : signed'(CRD_W'(r_rows_in_use));
        cols_e = (r_cols_in_use > MAX_COLS) ? CRD_W'(MAX_COLS)
                                            : signed'(CRD_W'(r_cols_in_use));
        x_end  = x_s + w_s;
        y_end  = y_s + h_s;
        border = (x_s <= 0) || (y_s <= 0) || (x_end >= cols_e) || (y_end >= rows_e);
        // clip to the grid; a check that passes the border test is unaffected
        r0 = (y_s < 0) ? '0 : y_s;
        r1 = (y_end > rows_e) ? rows_e : y_end;
        c0 = (x_s < 0) ? '0 : x_s;
        c1 = (x_end > cols_e) ? cols_e : x_end;
        empty_rng = (r0 >= r1) || (c0 >= c1);
    end

    // Scan position
    logic col_wrap, row_last;
    logic fill_we;

    assign col_wrap = (({1'b0, r_col} + (COL_W+1)'(1)) == r_col_end);
    assign row_last = (({1'b0, r_row} + (ROW_W+1)'(1)) == r_row_end);
    assign fill_we  = r_rd_vld && (r_op == OP_FILL) && (r_q != r_wall_code);

    always_comb begin
        o_sts           = '0;
        o_sts.clr_last  = &r_clr_addr;
        o_sts.skip      = r_skip;
        o_sts.scan_last = col_wrap && row_last;
        o_sts.hit       = r_hit;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= ROWS_RST;
            r_cols_in_use <= COLS_RST;
            r_wall_code   <= WALL_RST;
            r_empty_code  <= EMPTY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROWS_IN_USE: r_rows_in_use <= i_cfg_data[ROWS_CFG_W-1:0];
                CFG_COLS_IN_USE: r_cols_in_use <= i_cfg_data[COLS_CFG_W-1:0];
                CFG_WALL_CODE:   r_wall_code   <= i_cfg_data[CODE_W-1:0];
                CFG_EMPTY_CODE:  r_empty_code  <= i_cfg_data[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Control-side registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_rd_vld   <= 1'b0;
            r_hit      <= 1'b0;
        end else begin
            if (i_cmd.clear) r_clr_addr <= r_clr_addr + ADDR_W'(1);
            r_rd_vld <= i_cmd.issue;
            if (i_cmd.load) begin
                r_hit <= 1'b0;
            end else if (r_rd_vld && (r_op == OP_CHECK) && !r_hit &&
                         (r_q != r_empty_code)) begin
                r_hit <= 1'b1;
            end
        end
    end

    // Item capture, scan advance and hit value
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= i_opcode;
            r_code      <= i_fill_value;
            r_wall_hit  <= (i_opcode == OP_CHECK) && border;
            r_skip      <= ((i_opcode == OP_CHECK) && border) || empty_rng;
            r_row       <= r0[ROW_W-1:0];
            r_row_end   <= r1[ROW_W:0];
            r_col       <= c0[COL_W-1:0];
            r_col_start <= c0[COL_W-1:0];
            r_col_end   <= c1[COL_W:0];
        end else if (i_cmd.issue) begin
            if (col_wrap) begin
                r_col <= r_col_start;
                r_row <= r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
        if (i_cmd.issue) r_rd_addr <= {r_row, r_col};
        if (r_rd_vld && !r_hit) r_hit_val <= r_q;
        if (i_cmd.finish) begin
            r_res_check <= (r_op == OP_CHECK);
            if (r_op != OP_CHECK) r_res_code <= r_empty_code;
            else if (r_wall_hit) r_res_code <= r_wall_code;
            else if (r_hit) r_res_code <= r_hit_val;
            else r_res_code <= r_empty_code;
        end
    end

    // Cell grid: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) r_mem[r_clr_addr] <= '0;
        else if (fill_we) r_mem[r_rd_addr] <= r_code;
        r_q <= r_mem[{r_row, r_col}];
    end

    assign o_hit_code  = r_res_code;
    assign o_was_check = r_res_check;

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for grid_occupancy_rect_engine: random and directed rectangle
// fills and checks against a mirrored cell grid, across several register settings.
// Depends on gorect_pkg, gorect_in_if, gorect_out_if and the engine RTL.
module testbench;
    import gorect_pkg::*;

    typedef struct {
        logic        [OPCODE_W-1:0]      opcode;
        logic signed [RECT_X_W-1:0]      rect_x;
        logic signed [RECT_Y_W-1:0]      rect_y;
        logic        [RECT_WIDTH_W-1:0]  rect_width;
        logic        [RECT_HEIGHT_W-1:0] rect_height;
        logic        [CODE_W-1:0]        fill_value;
    } t_rect_item;

    typedef struct {
        logic [CODE_W-1:0] hit_code;
        logic              was_check;
    } t_rect_result;

    typedef enum {GAP_NONE, GAP_SENDER, GAP_RECEIVER, GAP_BOTH} t_gap_mode;

    localparam int HOLD_CYCLES = 600;
    localparam int TAIL_CYCLES = 64;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    gorect_in_if  item_if ();
    gorect_out_if result_if ();

    grid_occupancy_rect_engine dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_if),
        .o_result   (result_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Mirror of the cell grid and of the registers
    logic [CODE_W-1:0]     grid_mirror [MAX_ROWS][MAX_COLS];
    logic [ROWS_CFG_W-1:0] cfg_rows;
    logic [COLS_CFG_W-1:0] cfg_cols;
    logic [CODE_W-1:0]     cfg_wall;
    logic [CODE_W-1:0]     cfg_empty;

    t_rect_item   pending_rects [$];
    t_rect_result expected_hits [$];
    int           mismatch_count = 0;
    t_gap_mode    gap_mode;
    logic         hold_armed;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 4_000_000);
        $display("testbench: FAIL");
        $finish;
    end

    function automatic int used_rows();
        return (int'(cfg_rows) > MAX_ROWS) ? MAX_ROWS : int'(cfg_rows);
    endfunction

    function automatic int used_cols();
        return (int'(cfg_cols) > MAX_COLS) ? MAX_COLS : int'(cfg_cols);
    endfunction

    function automatic int gap_pct(bit receiver);
        case (gap_mode)
            GAP_SENDER:   return receiver ? 0 : 59;
            GAP_RECEIVER: return receiver ? 59 : 0;
            GAP_BOTH:     return 25;
            default:      return 0;
        endcase
    endfunction

    // Apply one accepted item to the grid mirror and return the result it owes
    function automatic t_rect_result apply_rect_op(t_rect_item it);
        t_rect_result res;
        int x, y, w, h, nr, nc, r1, c1;
        bit found;
        x  = int'(it.rect_x);
        y  = int'(it.rect_y);
        w  = int'(it.rect_width);
        h  = int'(it.rect_height);
        nr = used_rows();
        nc = used_cols();
        found = 1'b0;
        if (it.opcode == OP_CHECK) begin
            res.was_check = 1'b1;
            if (x <= 0 || y <= 0 || x + w >= nc || y + h >= nr) begin
                res.hit_code = cfg_wall;
            end else begin
                res.hit_code = cfg_empty;
                for (int i = y; i < y + h && !found; i++) begin
                    for (int j = x; j < x + w && !found; j++) begin
                        if (grid_mirror[i][j] != cfg_empty) begin
                            res.hit_code = grid_mirror[i][j];
                            found = 1'b1;
                        end
                    end
                end
            end
        end else begin
            r1 = (y + h > nr) ? nr : y + h;
            c1 = (x + w > nc) ? nc : x + w;
            // Clip to the grid in use; wall cells keep their code
            for (int i = (y < 0 ? 0 : y); i < r1; i++) begin
                for (int j = (x < 0 ? 0 : x); j < c1; j++) begin
                    if (grid_mirror[i][j] != cfg_wall)
                        grid_mirror[i][j] = it.fill_value;
                end
            end
            res.hit_code  = cfg_empty;
            res.was_check = 1'b0;
        end
        return res;
    endfunction

    function automatic t_rect_item make_rect(logic [OPCODE_W-1:0] op, int x, int y,
                                             int w, int h, int code);
        t_rect_item it;
        it.opcode      = op;
        it.rect_x      = RECT_X_W'(x);
        it.rect_y      = RECT_Y_W'(y);
        it.rect_width  = RECT_WIDTH_W'(w);
        it.rect_height = RECT_HEIGHT_W'(h);
        it.fill_value  = CODE_W'(code);
        return it;
    endfunction

    // Mostly sprite-sized fills and checks inside the grid, some at the frame,
    // some raw noise and the odd whole-grid sweep
    function automatic t_rect_item random_rect();
        int nr, nc, pick, x, y, w, h, code;
        nr   = used_rows();
        nc   = used_cols();
        pick = $urandom_range(99);
        code = $urandom_range(255);
        if (pick < 30) begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 6);
            x = int'($urandom_range(0, nc + 2)) - 2;
            y = int'($urandom_range(0, nr + 2)) - 2;
            case ($urandom_range(7))
                0: code = int'(cfg_wall);
                1: code = int'(cfg_empty);
                default: ;
            endcase
            return make_rect(OP_FILL, x, y, w, h, code);
        end else if (pick < 70 && nc >= 3 && nr >= 3) begin
            w = $urandom_range(0, (nc - 2 < 12) ? nc - 2 : 12);
            h = $urandom_range(0, (nr - 2 < 8) ? nr - 2 : 8);
            x = $urandom_range(1, nc - 1 - w);
            y = $urandom_range(1, nr - 1 - h);
            return make_rect(OP_CHECK, x, y, w, h, code);
        end else if (pick < 85) begin
            w = $urandom_range(0, 6);
            h = $urandom_range(0, 4);
            x = int'($urandom_range(0, nc + 1)) - 1;
            y = int'($urandom_range(0, nr + 1)) - 1;
            return make_rect(OP_CHECK, x, y, w, h, code);
        end else if (pick < 99) begin
            return make_rect(($urandom_range(1) != 0) ? OP_CHECK : OP_FILL,
                             $urandom, $urandom, $urandom, $urandom, code);
        end else if ($urandom_range(1)) begin
            if ($urandom_range(2) != 0)
                code = int'(cfg_empty);
            return make_rect(OP_FILL, 0, 0, nc, nr, code);
        end else begin
            return make_rect(OP_CHECK, 1, 1, (nc > 2) ? nc - 2 : 0, (nr > 2) ? nr - 2 : 0,
                             code);
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        case (idx)
            CFG_ROWS_IN_USE: cfg_rows  = ROWS_CFG_W'(value);
            CFG_COLS_IN_USE: cfg_cols  = COLS_CFG_W'(value);
            CFG_WALL_CODE:   cfg_wall  = CODE_W'(value);
            CFG_EMPTY_CODE:  cfg_empty = CODE_W'(value);
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_rects.size() != 0 || expected_hits.size() != 0);
    endtask

    task automatic run_phase(input int unsigned rows, input int unsigned cols,
                             input int unsigned wall, input int unsigned empty,
                             input t_gap_mode gaps, input int count, input bit with_hold);
        write_reg(CFG_ROWS_IN_USE, rows);
        write_reg(CFG_COLS_IN_USE, cols);
        write_reg(CFG_WALL_CODE, wall);
        write_reg(CFG_EMPTY_CODE, empty);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        gap_mode   <= gaps;
        hold_armed <= with_hold;
        @(negedge i_clk);
        repeat (count) pending_rects.push_back(random_rect());
        wait_drained();
        @(posedge i_clk);
        hold_armed <= 1'b0;
    endtask

    // Offer the oldest pending rectangle; predict its result on transfer
    always @(posedge i_clk) begin : rect_driver
        bit busy;
        if (!i_rst_n) begin
            item_if.valid       <= 1'b0;
            item_if.opcode      <= OP_FILL;
            item_if.rect_x      <= '0;
            item_if.rect_y      <= '0;
            item_if.rect_width  <= '0;
            item_if.rect_height <= '0;
            item_if.fill_value  <= '0;
        end else begin
            busy = item_if.valid;
            if (item_if.valid && item_if.ready) begin
                expected_hits.push_back(apply_rect_op(pending_rects.pop_front()));
                busy = 1'b0;
            end
            if (!busy) begin
                if (pending_rects.size() != 0 && $urandom_range(99) >= gap_pct(1'b0)) begin
                    item_if.opcode      <= pending_rects[0].opcode;
                    item_if.rect_x      <= pending_rects[0].rect_x;
                    item_if.rect_y      <= pending_rects[0].rect_y;
                    item_if.rect_width  <= pending_rects[0].rect_width;
                    item_if.rect_height <= pending_rects[0].rect_height;
                    item_if.fill_value  <= pending_rects[0].fill_value;
                    item_if.valid       <= 1'b1;
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : hit_monitor
        t_rect_result want;
        int hold_count;
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
            hold_count = 0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                if (expected_hits.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got hit_code %0h",
                             $time, result_if.hit_code);
                    mismatch_count++;
                end else begin
                    want = expected_hits.pop_front();
                    if (result_if.hit_code !== want.hit_code) begin
                        $display("%0t: hit_code mismatch, expected %0h, got %0h",
                                 $time, want.hit_code, result_if.hit_code);
                        mismatch_count++;
                    end
                    if (result_if.was_check !== want.was_check) begin
                        $display("%0t: was_check mismatch, expected %0b, got %0b",
                                 $time, want.was_check, result_if.was_check);
                        mismatch_count++;
                    end
                end
            end
            // Hold off for a long stretch so the engine backs up and stalls its input
            if (hold_armed && hold_count < HOLD_CYCLES) begin
                hold_count++;
                result_if.ready <= 1'b0;
            end else begin
                if (!hold_armed)
                    hold_count = 0;
                result_if.ready <= ($urandom_range(99) >= gap_pct(1'b1));
            end
        end
    end

    initial begin : stimulus
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = CFG_ROWS_IN_USE;
        i_cfg_data          = '0;
        gap_mode            = GAP_NONE;
        hold_armed          = 1'b0;
        cfg_rows            = ROWS_RST;
        cfg_cols            = COLS_RST;
        cfg_wall            = WALL_RST;
        cfg_empty           = EMPTY_RST;
        for (int i = 0; i < MAX_ROWS; i++)
            for (int j = 0; j < MAX_COLS; j++)
                grid_mirror[i][j] = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part on the reset settings: frame, clipping, walls, empty rectangles
        @(negedge i_clk);
        pending_rects.push_back(make_rect(OP_CHECK, 1, 1, 1, 1, 0));
        pending_rects.push_back(make_rect(OP_CHECK, 0, 5, 2, 2, 0));
        pending_rects.push_back(make_rect(OP_CHECK, -512, -512, 0, 0, 0));
        pending_rects.push_back(make_rect(OP_CHECK, 511, 511, 511, 127, 255));
        pending_rects.push_back(make_rect(OP_FILL, -512, -512, 0, 0, 255));
        pending_rects.push_back(make_rect(OP_CHECK, 5, 5, 0, 0, 0));
        pending_rects.push_back(make_rect(OP_FILL, -3, -2, 8, 6, 'hAA));
        pending_rects.push_back(make_rect(OP_CHECK, 1, 1, 3, 3, 0));
        pending_rects.push_back(make_rect(OP_FILL, 10, 10, 4, 2, 35));
        pending_rects.push_back(make_rect(OP_FILL, 9, 9, 8, 8, 'h55));
        pending_rects.push_back(make_rect(OP_CHECK, 10, 10, 4, 4, 0));
        pending_rects.push_back(make_rect(OP_CHECK, 9, 9, 3, 1, 0));
        pending_rects.push_back(make_rect(OP_FILL, 250, 60, 511, 127, 'h81));
        pending_rects.push_back(make_rect(OP_CHECK, 254, 62, 1, 1, 0));
        pending_rects.push_back(make_rect(OP_CHECK, 254, 62, 2, 1, 0));
        pending_rects.push_back(make_rect(OP_CHECK, 1, 1, 254, 62, 0));
        pending_rects.push_back(make_rect(OP_FILL, 0, 0, 256, 64, 0));
        pending_rects.push_back(make_rect(OP_CHECK, 1, 1, 254, 62, 0));
        pending_rects.push_back(make_rect(OP_FILL, -512, 0, 511, 1, 'h7F));
        pending_rects.push_back(make_rect(OP_FILL, 100, 30, 1, 1, 'hFF));
        pending_rects.push_back(make_rect(OP_CHECK, 100, 30, 1, 1, 0));
        wait_drained();

        run_phase(64, 256, 35, 0, GAP_NONE, 300, 1'b0);
        run_phase(12, 24, 255, 0, GAP_SENDER, 250, 1'b0);
        run_phase(1, 1, 35, 0, GAP_RECEIVER, 60, 1'b0);
        // Oversized dimensions, empty code no longer zero
        run_phase(127, 511, 0, 255, GAP_BOTH, 250, 1'b0);
        run_phase(0, 0, 200, 3, GAP_NONE, 40, 1'b0);
        run_phase(40, 100, 35, 7, GAP_NONE, 200, 1'b1);
        run_phase(64, 256, 35, 0, GAP_BOTH, 300, 1'b0);
        run_phase(2, 3, 'h5A, 'hA5, GAP_RECEIVER, 30, 1'b0);

        @(posedge i_clk);
        gap_mode <= GAP_NONE;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_hits.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
